@@ rtl/serial_flash_command_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Serial flash command sequencer assertion macros
// Assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SERIAL_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the antecedent implies the consequent in the same cycle
`define SFCS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfcs: same-cycle check failed");
// Check that the antecedent implies the consequent in the next cycle
`define SFCS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfcs: next-cycle check failed");
`else
`define SFCS_ASSERT_IMP(name, ante, cons)
`define SFCS_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ rtl/sfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcs_pkg
// Types, command codes and helpers shared by the flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // Flash geometry
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int CHUNK_W      = 13;
  localparam int MAX_RES      = 8;
  localparam int IDX_W        = $clog2(MAX_RES);
  localparam int CNT_W        = IDX_W + 1;

  // Flash opcodes
  localparam logic [7:0] CMD_WR_ENABLE = 8'h06;
  localparam logic [7:0] CMD_PP        = 8'h02;
  localparam logic [7:0] CMD_DATA_RD   = 8'h03;
  localparam logic [7:0] CMD_STATUS_RD = 8'h05;
  localparam logic [7:0] CMD_SE4K      = 8'h20;
  localparam logic [7:0] CMD_CE        = 8'hC7;
  localparam int         BUSY_BIT_POS  = 0;

  // Request types on the input channel
  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_PROG   = 3'd1,
    REQ_SERASE = 3'd2,
    REQ_CERASE = 3'd3,
    REQ_DATA   = 3'd4,
    REQ_STATUS = 3'd5
  } req_e;

  // Operation held for the current request
  typedef enum logic [1:0] {
    OPN_READ   = 2'd0,
    OPN_PROG   = 2'd1,
    OPN_SERASE = 2'd2,
    OPN_CERASE = 2'd3
  } opn_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RDATA = 2'd1,
    PH_WDATA = 2'd2,
    PH_POLL  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [23:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  // One SPI byte slot
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       capture;
    logic       cs_release;
    logic       done_res;
    logic       error;
  } slot_t;

  // All slots caused by one input item
  typedef struct packed {
    slot_t [MAX_RES-1:0] slots;
    logic  [CNT_W-1:0]   cnt;
  } burst_t;

  function automatic slot_t make_slot(logic [7:0] b, logic cap, logic rel,
                                      logic done, logic err);
    slot_t s;
    s.spi_byte   = b;
    s.capture    = cap;
    s.cs_release = rel;
    s.done_res   = done;
    s.error      = err;
    return s;
  endfunction

endpackage

@@ rtl/sfcs_in_reg.sv @@
// ----------------------------------------------------------------------------
// sfcs_in_reg
// Input register: holds one request beat until the engine takes it.
// ----------------------------------------------------------------------------
module sfcs_in_reg
  import sfcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  logic     accept;
  in_item_t item_q;

  // Stall only while a held beat is not being taken
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/sfcs_engine.sv @@
// ----------------------------------------------------------------------------
// sfcs_engine
// Sequencer state and the single-pass logic that turns one request beat into
// its list of SPI byte slots.
// ----------------------------------------------------------------------------
module sfcs_engine
  import sfcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     load_i,
  input  logic     addr_4byte_i,
  output burst_t   burst_o
);

  localparam logic [23:0]        PageBytesW = 24'(PAGE_BYTES);
  localparam logic [CHUNK_W-1:0] PageBytesC = CHUNK_W'(PAGE_BYTES);

  phase_e              phase_q, phase_d;
  opn_e                op_q, op_d;
  logic [31:0]         addr_q, addr_d;
  logic [23:0]         rem_q, rem_d;
  logic [CHUNK_W-1:0]  chunk_q, chunk_d;

  logic        err;
  logic        a_en, b_en, hdr_en, hdr_rel, poll_en;
  slot_t       a_slot, b_slot;
  logic [7:0]  hdr_op;
  logic [31:0] hdr_addr;
  logic        do_chunk, do_erase;
  logic        endc, fin;

  // Decide next state and which slot groups to emit
  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    chunk_d  = chunk_q;
    err      = 1'b0;
    a_en     = 1'b0;
    b_en     = 1'b0;
    a_slot   = '0;
    b_slot   = '0;
    hdr_en   = 1'b0;
    hdr_rel  = 1'b0;
    hdr_op   = CMD_DATA_RD;
    hdr_addr = '0;
    poll_en  = 1'b0;
    do_chunk = 1'b0;
    do_erase = 1'b0;
    endc     = 1'b0;
    fin      = 1'b0;

    case (item_i.req_type)
      REQ_READ, REQ_PROG, REQ_SERASE, REQ_CERASE: begin
        if (phase_q != PH_IDLE) begin
          err = 1'b1;
        end else begin
          op_d   = opn_e'(item_i.req_type[1:0]);
          addr_d = item_i.address;
          if (item_i.req_type == REQ_CERASE) begin
            rem_d   = '0;
            a_en    = 1'b1;
            a_slot  = make_slot(CMD_WR_ENABLE, 1'b0, 1'b1, 1'b0, 1'b0);
            b_en    = 1'b1;
            b_slot  = make_slot(CMD_CE, 1'b0, 1'b1, 1'b0, 1'b0);
            poll_en = 1'b1;
          end else if (item_i.length == '0) begin
            rem_d   = '0;
            a_en    = 1'b1;
            a_slot  = make_slot(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
            phase_d = PH_IDLE;
          end else if (item_i.req_type == REQ_SERASE) begin
            rem_d    = item_i.length - 24'd1;
            do_erase = 1'b1;
          end else begin
            rem_d    = item_i.length;
            do_chunk = 1'b1;
          end
        end
      end
      REQ_DATA: begin
        if (phase_q == PH_RDATA || phase_q == PH_WDATA) begin
          rem_d   = rem_q - 24'd1;
          chunk_d = chunk_q - CHUNK_W'(1);
          addr_d  = addr_q + 32'd1;
          endc    = (chunk_d == '0);
          if (phase_q == PH_RDATA) begin
            fin    = endc && (rem_d == '0);
            a_en   = 1'b1;
            a_slot = make_slot(8'h00, 1'b1, endc, fin, 1'b0);
            if (fin) begin
              phase_d = PH_IDLE;
            end else if (endc) begin
              do_chunk = 1'b1;
            end
          end else begin
            a_en    = 1'b1;
            a_slot  = make_slot(item_i.data_byte, 1'b0, endc, 1'b0, 1'b0);
            poll_en = endc;
          end
        end else begin
          err = 1'b1;
        end
      end
      REQ_STATUS: begin
        if (phase_q != PH_POLL) begin
          err = 1'b1;
        end else if (item_i.data_byte[BUSY_BIT_POS]) begin
          poll_en = 1'b1;
        end else if (op_q == OPN_PROG && rem_q != '0) begin
          do_chunk = 1'b1;
        end else if (op_q == OPN_SERASE && rem_q != '0) begin
          rem_d    = rem_q - 24'd1;
          addr_d   = addr_q + 32'd1;
          do_erase = 1'b1;
        end else begin
          a_en    = 1'b1;
          a_slot  = make_slot(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          phase_d = PH_IDLE;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // Open the next read or program chunk
    if (do_chunk) begin
      chunk_d  = (rem_d > PageBytesW) ? PageBytesC : rem_d[CHUNK_W-1:0];
      hdr_en   = 1'b1;
      hdr_addr = addr_d;
      if (op_d == OPN_PROG) begin
        a_en    = 1'b1;
        a_slot  = make_slot(CMD_WR_ENABLE, 1'b0, 1'b1, 1'b0, 1'b0);
        hdr_op  = CMD_PP;
        phase_d = PH_WDATA;
      end else begin
        hdr_op  = CMD_DATA_RD;
        phase_d = PH_RDATA;
      end
    end

    // Issue one sector erase followed by a status poll
    if (do_erase) begin
      a_en     = 1'b1;
      a_slot   = make_slot(CMD_WR_ENABLE, 1'b0, 1'b1, 1'b0, 1'b0);
      hdr_en   = 1'b1;
      hdr_op   = CMD_SE4K;
      hdr_rel  = 1'b1;
      hdr_addr = addr_d << SECTOR_SHIFT;
      poll_en  = 1'b1;
    end

    if (poll_en) begin
      phase_d = PH_POLL;
    end
  end

  // Pack the slot groups into one burst
  always_comb begin
    logic [CNT_W-1:0] n;
    n       = '0;
    burst_o = '0;
    if (err) begin
      burst_o.slots[0] = make_slot(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      n = CNT_W'(1);
    end else begin
      if (a_en) begin
        burst_o.slots[n[IDX_W-1:0]] = a_slot;
        n = n + CNT_W'(1);
      end
      if (b_en) begin
        burst_o.slots[n[IDX_W-1:0]] = b_slot;
        n = n + CNT_W'(1);
      end
      if (hdr_en) begin
        burst_o.slots[n[IDX_W-1:0]] = make_slot(hdr_op, 1'b0, 1'b0, 1'b0, 1'b0);
        n = n + CNT_W'(1);
        if (addr_4byte_i) begin
          burst_o.slots[n[IDX_W-1:0]] =
            make_slot(hdr_addr[31:24], 1'b0, 1'b0, 1'b0, 1'b0);
          n = n + CNT_W'(1);
        end
        burst_o.slots[n[IDX_W-1:0]] = make_slot(hdr_addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
        n = n + CNT_W'(1);
        burst_o.slots[n[IDX_W-1:0]] = make_slot(hdr_addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
        n = n + CNT_W'(1);
        burst_o.slots[n[IDX_W-1:0]] = make_slot(hdr_addr[7:0], 1'b0, hdr_rel, 1'b0, 1'b0);
        n = n + CNT_W'(1);
      end
      if (poll_en) begin
        burst_o.slots[n[IDX_W-1:0]] = make_slot(CMD_STATUS_RD, 1'b0, 1'b0, 1'b0, 1'b0);
        n = n + CNT_W'(1);
        burst_o.slots[n[IDX_W-1:0]] = make_slot(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
        n = n + CNT_W'(1);
      end
    end
    burst_o.cnt = n;
  end

  // Advance state when the burst is taken; an error beat leaves it as is
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OPN_READ;
      addr_q  <= '0;
      rem_q   <= '0;
      chunk_q <= '0;
    end else if (load_i && !err) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      chunk_q <= chunk_d;
    end
  end

endmodule

@@ rtl/sfcs_out_burst.sv @@
// ----------------------------------------------------------------------------
// sfcs_out_burst
// Result register: holds one burst of slots and drains it one beat a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sfcs_out_burst
  import sfcs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  burst_t burst_i,
  input  logic   load_i,
  output logic   load_ok_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output slot_t  slot_o,
  output logic   last_o
);

  logic             bvalid_q;
  logic [IDX_W-1:0] idx_q;
  burst_t           burst_q;
  logic             fire;
  logic             last_beat;

  assign fire      = bvalid_q && !out_stall_i;
  assign last_beat = ({1'b0, idx_q} == (burst_q.cnt - CNT_W'(1)));
  assign load_ok_o = !bvalid_q || (fire && last_beat);

  // Load a new burst or step through the held one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= '0;
    end else if (load_i) begin
      bvalid_q <= 1'b1;
      idx_q    <= '0;
    end else if (fire) begin
      if (last_beat) begin
        bvalid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o = bvalid_q;
  assign slot_o      = burst_q.slots[idx_q];
  assign last_o      = last_beat;

endmodule

@@ rtl/serial_flash_command_sequencer.sv @@
// An accepted request beat waits in the input register; its burst is then registered in the result register.
// Each request beat yields one to eight result beats, one per cycle unless the
// output stalls; the next request beat enters the input register while the
// previous burst drains and is taken as the last beat of that burst leaves.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, clears the
// engine state and the 4-byte address mode, and empties both registers.
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer
// SPI NOR flash command sequencer: turns read, program and erase requests
// into framed SPI byte slots with write enable and status polling.
// ----------------------------------------------------------------------------
`include "serial_flash_command_sequencer_defines.svh"

module serial_flash_command_sequencer
  import sfcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_4byte_i,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [23:0] length_i,
  input  logic [7:0]  data_byte_i,
  // Slot channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  spi_byte_o,
  output logic        capture_o,
  output logic        cs_release_o,
  output logic        done_res_o,
  output logic        error_o,
  output logic        last_o
);

  logic     addr_4byte_q;
  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     load_ok;
  logic     take;
  burst_t   burst;
  slot_t    slot;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_4byte_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      addr_4byte_q <= cfg_addr_4byte_i;
    end
  end

  assign in_item.req_type  = req_type_i;
  assign in_item.address   = address_i;
  assign in_item.length    = length_i;
  assign in_item.data_byte = data_byte_i;

  assign take = held_valid && load_ok;

  sfcs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  sfcs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (held_item),
    .load_i       (take),
    .addr_4byte_i (addr_4byte_q),
    .burst_o      (burst)
  );

  sfcs_out_burst u_out_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .load_i      (take),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .slot_o      (slot),
    .last_o      (last_o)
  );

  assign spi_byte_o   = slot.spi_byte;
  assign capture_o    = slot.capture;
  assign cs_release_o = slot.cs_release;
  assign done_res_o   = slot.done_res;
  assign error_o      = slot.error;

  // An error beat stands alone
  `SFCS_ASSERT_IMP(a_err_last, out_valid_o && error_o, last_o)
  // Completion always closes the burst
  `SFCS_ASSERT_IMP(a_done_last, out_valid_o && done_res_o, last_o)
  // Capture slots shift out zero
  `SFCS_ASSERT_IMP(a_cap_zero, out_valid_o && capture_o, spi_byte_o == 8'h00)
  // A burst never ends without a pending beat being drained or replaced
  `SFCS_ASSERT_NXT(a_hold_burst, out_valid_o && out_stall_i, out_valid_o)

endmodule
